@@ design/matrix_vector_multiply_stream_unit_macros.svh @@
// Assertion macros shared by the checkers of the matrix-vector multiply unit.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef MATRIX_VECTOR_MULTIPLY_STREAM_UNIT_MACROS_SVH
`define MATRIX_VECTOR_MULTIPLY_STREAM_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MVM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MVM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/mvm_pkg.sv @@
// Package for the matrix-vector multiply unit: sizes, codes and the structs
// passed between the controller and the chain of row cells. No dependencies.
`default_nettype none

package mvm_pkg;

  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 64;

  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int NROW_W = $clog2(MAX_ROWS + 1);
  localparam int NCOL_W = $clog2(MAX_COLS + 1);
  localparam int WAIT_W = $clog2(MAX_ROWS + 2);

  localparam int ROW_FW     = 4;
  localparam int COL_FW     = 6;
  localparam int COEF_W     = 16;
  localparam int SAMP_W     = 16;
  localparam int PROD_W     = COEF_W + SAMP_W;
  localparam int ACC_W      = 40;
  localparam int RCFG_W     = 5;
  localparam int CCFG_W     = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam int RST_ROWS = 16;
  localparam int RST_COLS = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } st_t;

  typedef struct packed {
    logic                     vld;
    logic signed [SAMP_W-1:0] sample;
    logic [COL_W-1:0]         col;
    logic [NROW_W-1:0]        nrows;
  } tok_t;

  typedef struct packed {
    logic                     vld;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [COEF_W-1:0] value;
  } wr_t;

  typedef struct packed {
    tok_t tok;
    wr_t  wr;
    logic shift;
  } chain_ctl_t;

endpackage

`default_nettype wire

@@ design/mvm_cell.sv @@
// One row cell: the row's coefficient memory, a multiplier and the row accumulator.
// Hands the sample request on to the next cell each cycle. Depends on mvm_pkg.
`default_nettype none

module mvm_cell import mvm_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [ROW_W-1:0]        row_id,
  input  wire tok_t                    tok_in,
  input  wire wr_t                     wr,
  input  wire logic                    shift,
  input  wire logic signed [ACC_W-1:0] acc_in,
  output tok_t                         tok_out,
  output logic signed [ACC_W-1:0]      acc_out
);

  logic signed [COEF_W-1:0] coef_mem [MAX_COLS];

  logic signed [COEF_W-1:0] coef_q_r;
  logic signed [SAMP_W-1:0] s1_sample_r;
  logic                     s1_vld_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     s2_vld_r;
  logic signed [ACC_W-1:0]  acc_r;
  tok_t                     tok_r;
  logic                     active;

  assign active  = tok_in.vld && ({1'b0, row_id} < (ROW_W + 1)'(tok_in.nrows));
  assign tok_out = tok_r;
  assign acc_out = acc_r;

  always_ff @(posedge clk) begin
    if (wr.vld && (wr.row == row_id)) begin
      coef_mem[wr.col] <= wr.value;
    end
    coef_q_r    <= coef_mem[tok_in.col];
    s1_sample_r <= tok_in.sample;
    prod_r      <= PROD_W'(coef_q_r) * PROD_W'(s1_sample_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r    <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      acc_r    <= '0;
    end else begin
      tok_r    <= tok_in;
      s1_vld_r <= active;
      s2_vld_r <= s1_vld_r;
      if (shift) begin
        acc_r <= acc_in;
      end else if (s2_vld_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
  end

endmodule

`default_nettype wire

@@ design/mvm_chain.sv @@
// The row of cells, one per matrix row, with sample requests passing downwards
// and accumulators shifting towards cell zero on readout. Depends on mvm_pkg, mvm_cell.
`default_nettype none

module mvm_chain import mvm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire chain_ctl_t         ctl,
  output logic signed [ACC_W-1:0] head_acc
);

  tok_t                    tok_w [MAX_ROWS];
  logic signed [ACC_W-1:0] acc_w [MAX_ROWS];

  for (genvar g = 0; g < MAX_ROWS; g++) begin : g_cell
    tok_t                    tok_in;
    logic signed [ACC_W-1:0] acc_in;

    if (g == 0) begin : g_head
      assign tok_in = ctl.tok;
    end else begin : g_body
      assign tok_in = tok_w[g-1];
    end

    if (g == MAX_ROWS - 1) begin : g_tail
      assign acc_in = '0;
    end else begin : g_link
      assign acc_in = acc_w[g+1];
    end

    mvm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .row_id  (ROW_W'(g)),
      .tok_in  (tok_in),
      .wr      (ctl.wr),
      .shift   (ctl.shift),
      .acc_in  (acc_in),
      .tok_out (tok_w[g]),
      .acc_out (acc_w[g])
    );
  end

  assign head_acc = acc_w[0];

endmodule

`default_nettype wire

@@ design/mvm_ctrl.sv @@
// Controller: configuration registers, request acceptance, column counting,
// readout sequencing and the result register. Depends on mvm_pkg.
`default_nettype none

module mvm_ctrl import mvm_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_req_type,
  input  wire logic [ROW_FW-1:0]        in_coef_row,
  input  wire logic [COL_FW-1:0]        in_coef_col,
  input  wire logic signed [COEF_W-1:0] in_coef_value,
  input  wire logic signed [SAMP_W-1:0] in_sample_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [ROW_FW-1:0]             out_row_index,
  output logic signed [ACC_W-1:0]       out_feature_value,
  output logic                          out_last_row,
  output chain_ctl_t                    ctl,
  input  wire logic signed [ACC_W-1:0]  head_acc
);

  st_t                     st_r, st_nxt;
  logic [RCFG_W-1:0]       rows_r;
  logic [CCFG_W-1:0]       cols_r;
  logic [COL_W-1:0]        col_r, col_nxt;
  logic                    pend_r, pend_nxt;
  logic [WAIT_W-1:0]       wait_r, wait_nxt;
  logic [NROW_W-1:0]       drn_r, drn_nxt;
  logic [NROW_W-1:0]       drows_r, drows_nxt;
  logic                    oval_r, oval_nxt;
  logic [ROW_FW-1:0]       orow_r, orow_nxt;
  logic signed [ACC_W-1:0] oacc_r, oacc_nxt;
  logic                    olast_r, olast_nxt;

  logic [NROW_W-1:0] nrows;
  logic [NCOL_W-1:0] ncols;
  logic              accept;
  logic              vec_done;
  logic              load_ok;
  logic              need_out;
  logic              slot_free;

  always_comb begin
    if (rows_r == '0) begin
      nrows = NROW_W'(1);
    end else if (32'(rows_r) > MAX_ROWS) begin
      nrows = NROW_W'(MAX_ROWS);
    end else begin
      nrows = NROW_W'(rows_r);
    end
    if (cols_r == '0) begin
      ncols = NCOL_W'(1);
    end else if (32'(cols_r) > MAX_COLS) begin
      ncols = NCOL_W'(MAX_COLS);
    end else begin
      ncols = NCOL_W'(cols_r);
    end
  end

  assign in_stall  = (st_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign vec_done  = (32'(col_r) + 32'd1) >= 32'(ncols);
  assign load_ok   = (32'(in_coef_row) < MAX_ROWS) && (32'(in_coef_col) < MAX_COLS);
  assign need_out  = drn_r < drows_r;
  assign slot_free = !oval_r || !out_stall;

  assign out_valid         = oval_r;
  assign out_row_index     = orow_r;
  assign out_feature_value = oacc_r;
  assign out_last_row      = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt    = st_r;
    col_nxt   = col_r;
    pend_nxt  = pend_r;
    wait_nxt  = wait_r;
    drn_nxt   = drn_r;
    drows_nxt = drows_r;
    oval_nxt  = oval_r;
    orow_nxt  = orow_r;
    oacc_nxt  = oacc_r;
    olast_nxt = olast_r;

    ctl.tok.vld    = 1'b0;
    ctl.tok.sample = in_sample_value;
    ctl.tok.col    = col_r;
    ctl.tok.nrows  = nrows;
    ctl.wr.vld     = 1'b0;
    ctl.wr.row     = ROW_W'(in_coef_row);
    ctl.wr.col     = COL_W'(in_coef_col);
    ctl.wr.value   = in_coef_value;
    ctl.shift      = 1'b0;

    if (oval_r && !out_stall) begin
      oval_nxt = 1'b0;
    end

    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          if (req_t'(in_req_type) == REQ_SAMPLE) begin
            ctl.tok.vld = 1'b1;
            col_nxt     = vec_done ? '0 : col_r + COL_W'(1);
            pend_nxt    = vec_done;
            drows_nxt   = nrows;
            wait_nxt    = WAIT_W'(MAX_ROWS + 1);
            st_nxt      = ST_RUN;
          end else begin
            ctl.wr.vld = load_ok;
          end
        end
      end
      ST_RUN: begin
        wait_nxt = wait_r - WAIT_W'(1);
        if (wait_r == WAIT_W'(1)) begin
          drn_nxt = '0;
          st_nxt  = pend_r ? ST_DRAIN : ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (!need_out || slot_free) begin
          ctl.shift = 1'b1;
          if (need_out) begin
            oval_nxt  = 1'b1;
            orow_nxt  = ROW_FW'(drn_r);
            oacc_nxt  = head_acc;
            olast_nxt = (32'(drn_r) + 32'd1) == 32'(drows_r);
          end
          drn_nxt = drn_r + NROW_W'(1);
          if (32'(drn_r) == MAX_ROWS - 1) begin
            st_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= RCFG_W'(RST_ROWS);
      cols_r  <= CCFG_W'(RST_COLS);
      col_r   <= '0;
      pend_r  <= 1'b0;
      wait_r  <= '0;
      drn_r   <= '0;
      drows_r <= '0;
      oval_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ROWS: rows_r <= cfg_wdata[RCFG_W-1:0];
          CFG_COLS: cols_r <= cfg_wdata[CCFG_W-1:0];
          default: begin
          end
        endcase
      end
      col_r   <= col_nxt;
      pend_r  <= pend_nxt;
      wait_r  <= wait_nxt;
      drn_r   <= drn_nxt;
      drows_r <= drows_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    orow_r  <= orow_nxt;
    oacc_r  <= oacc_nxt;
    olast_r <= olast_nxt;
  end

endmodule

`default_nettype wire

@@ design/matrix_vector_multiply_stream_unit.sv @@
// Top level of the streaming matrix-vector multiply unit.
// Depends on mvm_pkg, mvm_ctrl and mvm_chain.
//
//   Channel  Direction  Handshake            Carries
//   in_      request    in_valid / in_stall  coefficient load or one vector sample
//   out_     result     out_valid/out_stall  row index, Q18.22 feature, last-row flag
//   cfg_     write      cfg_wr_en            rows in use, columns in use
//
// A load request leaves the input free. A sample request stalls the input while it
// ripples through the cell chain and reaches the last row's accumulator. The sample
// that closes a vector adds a readout that shifts all MAX_ROWS accumulators out through
// cell zero and pauses while out_stall holds a result. Reset is synchronous and clears
// the accumulators, counters and valid flags; coefficient memories and data registers
// are not cleared. A result waiting after the readout does not hold back requests.
`default_nettype none

module matrix_vector_multiply_stream_unit import mvm_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_req_type,
  input  wire logic [ROW_FW-1:0]        in_coef_row,
  input  wire logic [COL_FW-1:0]        in_coef_col,
  input  wire logic signed [COEF_W-1:0] in_coef_value,
  input  wire logic signed [SAMP_W-1:0] in_sample_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [ROW_FW-1:0]             out_row_index,
  output logic signed [ACC_W-1:0]       out_feature_value,
  output logic                          out_last_row
);

  chain_ctl_t              ctl;
  logic signed [ACC_W-1:0] head_acc;

  mvm_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_coef_row       (in_coef_row),
    .in_coef_col       (in_coef_col),
    .in_coef_value     (in_coef_value),
    .in_sample_value   (in_sample_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_row_index     (out_row_index),
    .out_feature_value (out_feature_value),
    .out_last_row      (out_last_row),
    .ctl               (ctl),
    .head_acc          (head_acc)
  );

  mvm_chain u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .head_acc (head_acc)
  );

endmodule

`default_nettype wire

@@ design/mvm_checker.sv @@
// Port-level checker for the matrix-vector multiply unit, bound to the top level.
// Depends on mvm_pkg and the assertion macro header.
`default_nettype none

`include "matrix_vector_multiply_stream_unit_macros.svh"

module mvm_checker import mvm_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_valid,
  input wire logic                     in_stall,
  input wire logic                     in_req_type,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic [ROW_FW-1:0]        out_row_index,
  input wire logic signed [ACC_W-1:0]  out_feature_value,
  input wire logic                     out_last_row
);

  // A stalled result must stay offered and unchanged.
  `MVM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result withdrawn")
  `MVM_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_row_index) && $stable(out_feature_value) && $stable(out_last_row), "stalled result changed")

  // An accepted sample request leaves the unit busy, so the input is stalled.
  `MVM_ASSERT_NEXT(a_sample_busy, in_valid && !in_stall && in_req_type, in_stall, "sample request not followed by a busy cycle")

  // A load request leaves the input free, with no busy state.
  `MVM_ASSERT_NEXT(a_load_quick, in_valid && !in_stall && !in_req_type, !in_stall, "load request held the input")

  // Further rows follow a result that is not the last, so the readout is still running.
  `MVM_ASSERT_NOW(a_drain_busy, out_valid && !out_last_row, in_stall, "request accepted during readout")

endmodule

bind matrix_vector_multiply_stream_unit mvm_checker u_mvm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_req_type       (in_req_type),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_row_index     (out_row_index),
  .out_feature_value (out_feature_value),
  .out_last_row      (out_last_row)
);

`default_nettype wire
